### hw/rtl/rda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rda_pkg;

  localparam int unsigned NUM_DIGITS_DEF = 8;
  localparam int unsigned MAX_DIGITS     = 8;
  localparam logic [7:0]  STEP_PERIOD_RST = 8'd60;
  localparam logic [7:0]  TICK_SAT        = 8'hFF;
  localparam logic [3:0]  DIGIT_MAX       = 4'd9;
  localparam logic [3:0]  DIGIT_BASE      = 4'd10;
  localparam logic [3:0]  HALF_TURN       = 4'd5;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

  typedef struct packed {
    logic [31:0] shown_digits;
    logic [63:0] segment_pattern;
    logic        busy_res;
    logic        done_res;
  } res_t;

  function automatic logic [3:0] clamp_digit(input logic [3:0] d);
    clamp_digit = (d > DIGIT_MAX) ? DIGIT_MAX : d;
  endfunction

  // bit1 A .. bit7 G, bit0 unused
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h7E;
      4'd1: s = 8'h0C;
      4'd2: s = 8'hB6;
      4'd3: s = 8'h9E;
      4'd4: s = 8'hCC;
      4'd5: s = 8'hDA;
      4'd6: s = 8'hFA;
      4'd7: s = 8'h0E;
      4'd8: s = 8'hFE;
      4'd9: s = 8'hDE;
      default: s = 8'h00;
    endcase
    seg_of = s;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rda_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module rda_lane (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rda_pkg::lane_ctrl_t ctrl,
  input  wire logic [3:0]          src_digit,
  input  wire logic                src_valid,
  input  wire logic [3:0]          tgt_digit,
  input  wire logic                tgt_valid,
  output logic                     moving,
  output logic [3:0]               digit_nxt,
  output logic [7:0]               seg_nxt
);

  logic [3:0] cur_r, goal_r;
  logic       mask_r;
  logic [3:0] goal_nxt;
  logic       mask_nxt;
  logic [3:0] up_dist;
  logic [3:0] cur_up, cur_down;

  assign moving   = mask_r && (cur_r != goal_r);
  assign up_dist  = (goal_r >= cur_r) ? (goal_r - cur_r) : (goal_r + rda_pkg::DIGIT_BASE - cur_r);
  assign cur_up   = (cur_r == rda_pkg::DIGIT_MAX) ? 4'd0 : cur_r + 4'd1;
  assign cur_down = (cur_r == 4'd0) ? rda_pkg::DIGIT_MAX : cur_r - 4'd1;

  always_comb begin
    digit_nxt = cur_r;
    goal_nxt  = goal_r;
    mask_nxt  = mask_r;
    if (ctrl.load) begin
      digit_nxt = src_valid ? rda_pkg::clamp_digit(src_digit) : 4'd0;
      goal_nxt  = rda_pkg::clamp_digit(tgt_digit);
      mask_nxt  = tgt_valid;
    end else if (ctrl.step && moving) begin
      // shorter way around, up on a tie
      digit_nxt = (up_dist <= rda_pkg::HALF_TURN) ? cur_up : cur_down;
    end
    seg_nxt = mask_nxt ? rda_pkg::seg_of(digit_nxt) : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= 4'd0;
      goal_r <= 4'd0;
      mask_r <= 1'b0;
    end else begin
      cur_r  <= digit_nxt;
      goal_r <= goal_nxt;
      mask_r <= mask_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rda_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none
module rda_outbuf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rda_pkg::res_t push_word,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rda_pkg::res_t      out_word
);

  logic          head_valid_r, skid_valid_r;
  rda_pkg::res_t head_r, skid_r;
  logic          pop;

  assign pop       = head_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_word  = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!head_valid_r || pop) begin
      if (skid_valid_r) begin
        head_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        head_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid_r || pop) begin
      head_r <= skid_valid_r ? skid_r : push_word;
    end else if (push) begin
      // hold head, park the new word
      skid_r <= push_word;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rolling_digit_animator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Rolling digit animator: up to eight decimal digits roll one place per step toward
// their targets, the shorter way around. A start word (action 0) loads digits and
// masks; each tick word (action 1) counts toward cfg step_period and a step is taken
// when the count is reached. Every accepted word yields one registered result word; the
// block takes one word per cycle while in_stall is low, all lanes updating in parallel;
// in_stall rises only once a two-word output buffer is full behind a stalled out_stall.
module rolling_digit_animator_top #(
  parameter int unsigned NUM_DIGITS = rda_pkg::NUM_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [31:0] in_source_digits,
  input  wire logic [7:0]  in_source_valid,
  input  wire logic [31:0] in_target_digits,
  input  wire logic [7:0]  in_target_valid,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_shown_digits,
  output logic [63:0]      out_segment_pattern,
  output logic             out_busy_res,
  output logic             out_done_res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_step_period
);

  logic [7:0]          step_period_r;
  logic                running_r, running_nxt;
  logic [7:0]          tick_count_r, tick_count_nxt;
  logic [7:0]          tick_inc;
  logic                accept, done, step;
  rda_pkg::lane_ctrl_t ctrl;
  logic [NUM_DIGITS-1:0] lane_moving;
  logic [3:0]          lane_digit [NUM_DIGITS];
  logic [7:0]          lane_seg   [NUM_DIGITS];
  rda_pkg::res_t       res, out_word;
  logic                buf_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !in_stall;
  assign tick_inc  = tick_count_r + 8'd1;

  always_comb begin
    running_nxt    = running_r;
    tick_count_nxt = tick_count_r;
    done           = 1'b0;
    step           = 1'b0;
    ctrl.load      = 1'b0;
    if (accept) begin
      if (rda_pkg::action_t'(in_action) == rda_pkg::ACT_START) begin
        ctrl.load      = 1'b1;
        running_nxt    = 1'b1;
        tick_count_nxt = 8'd0;
      end else if (running_r) begin
        tick_count_nxt = tick_inc;
        if (tick_inc >= step_period_r || tick_inc == rda_pkg::TICK_SAT) begin
          step           = 1'b1;
          tick_count_nxt = 8'd0;
          // merge: a step with no lane moving ends the run
          if (!(|lane_moving)) begin
            running_nxt = 1'b0;
            done        = 1'b1;
          end
        end
      end
    end
    ctrl.step = step;
  end

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_lane
    rda_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .src_digit (in_source_digits[4*i +: 4]),
      .src_valid (in_source_valid[i]),
      .tgt_digit (in_target_digits[4*i +: 4]),
      .tgt_valid (in_target_valid[i]),
      .moving    (lane_moving[i]),
      .digit_nxt (lane_digit[i]),
      .seg_nxt   (lane_seg[i])
    );
  end

  always_comb begin
    res = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      res.shown_digits[4*i +: 4]    = lane_digit[i];
      res.segment_pattern[8*i +: 8] = lane_seg[i];
    end
    res.busy_res = running_nxt;
    res.done_res = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r <= rda_pkg::STEP_PERIOD_RST;
      running_r     <= 1'b0;
      tick_count_r  <= 8'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_period_r <= cfg_step_period;
      end
      running_r    <= running_nxt;
      tick_count_r <= tick_count_nxt;
    end
  end

  rda_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_word (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_shown_digits    = out_word.shown_digits;
  assign out_segment_pattern = out_word.segment_pattern;
  assign out_busy_res        = out_word.busy_res;
  assign out_done_res        = out_word.done_res;

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int NDIG      = rda_pkg::NUM_DIGITS_DEF;
  localparam int NO_CFG    = -1;
  localparam int RUN_WORDS = 1650;
  localparam int LIMIT     = 400000;

  typedef struct packed {
    rda_pkg::action_t action;
    logic [31:0]      src;
    logic [7:0]       srcv;
    logic [31:0]      tgt;
    logic [7:0]       tgtv;
  } word_t;

  typedef struct {
    int            new_period;
    word_t         w;
    bit            typed;
    rda_pkg::res_t want;
  } dir_row_t;

  localparam word_t TICK_W = '{rda_pkg::ACT_TICK, 32'h0, 8'h0, 32'h0, 8'h0};
  localparam rda_pkg::res_t NO_RES = '0;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [31:0] in_source_digits = '0;
  logic [7:0]  in_source_valid = '0;
  logic [31:0] in_target_digits = '0;
  logic [7:0]  in_target_valid = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_shown_digits;
  logic [63:0] out_segment_pattern;
  logic        out_busy_res;
  logic        out_done_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_step_period = '0;

  rolling_digit_animator_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_source_digits   (in_source_digits),
    .in_source_valid    (in_source_valid),
    .in_target_digits   (in_target_digits),
    .in_target_valid    (in_target_valid),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_shown_digits   (out_shown_digits),
    .out_segment_pattern(out_segment_pattern),
    .out_busy_res       (out_busy_res),
    .out_done_res       (out_done_res),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_step_period    (cfg_step_period)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Digit roller state, mirrored from the block
  logic [3:0] cur_d  [NDIG];
  logic [3:0] goal_d [NDIG];
  logic [7:0] part_mask;
  logic       run_flag;
  logic [7:0] tick_cnt;
  logic [7:0] period;

  logic [7:0] seg_lut [10] = '{8'h7E, 8'h0C, 8'hB6, 8'h9E, 8'hCC,
                               8'hDA, 8'hFA, 8'h0E, 8'hFE, 8'hDE};

  rda_pkg::res_t roll_q[$];
  int   err_cnt = 0;
  int   live_words = 0;
  int   n_checked = 0;
  int   n_done = 0;
  int   n_cfg = 0;
  int   cycle_cnt = 0;
  int   stall_left = 0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;

  function automatic logic [3:0] sat_nine(input logic [3:0] d);
    return (d > 4'd9) ? 4'd9 : d;
  endfunction

  function automatic rda_pkg::res_t predict_roll(input word_t w);
    rda_pkg::res_t r;
    logic moved;
    int   up;
    r = '0;
    moved = 1'b0;
    if (w.action == rda_pkg::ACT_START) begin
      for (int i = 0; i < NDIG; i++) begin
        cur_d[i]  = w.srcv[i] ? sat_nine(w.src[4*i +: 4]) : 4'd0;
        goal_d[i] = sat_nine(w.tgt[4*i +: 4]);
      end
      part_mask = w.tgtv;
      run_flag  = 1'b1;
      tick_cnt  = '0;
    end else if (run_flag) begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= period || tick_cnt == rda_pkg::TICK_SAT) begin
        tick_cnt = '0;
        for (int i = 0; i < NDIG; i++) begin
          if (part_mask[i] && cur_d[i] != goal_d[i]) begin
            // take the shorter way; a half turn goes up
            up = (int'(goal_d[i]) + 10 - int'(cur_d[i])) % 10;
            if (up <= 10 - up) cur_d[i] = (cur_d[i] == 4'd9) ? 4'd0 : cur_d[i] + 4'd1;
            else cur_d[i] = (cur_d[i] == 4'd0) ? 4'd9 : cur_d[i] - 4'd1;
            moved = 1'b1;
          end
        end
        if (!moved) begin
          run_flag = 1'b0;
          r.done_res = 1'b1;
        end
      end
    end
    for (int i = 0; i < NDIG; i++) begin
      r.shown_digits[4*i +: 4] = cur_d[i];
      if (part_mask[i]) r.segment_pattern[8*i +: 8] = seg_lut[cur_d[i]];
    end
    r.busy_res = run_flag;
    return r;
  endfunction

  function automatic word_t rand_word(input rda_pkg::action_t a);
    word_t w;
    w.action = a;
    w.src    = $urandom;
    w.srcv   = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
    w.tgt    = $urandom;
    w.tgtv   = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
    return w;
  endfunction

  task automatic send_word(input word_t w, input bit typed, input rda_pkg::res_t want);
    int            gap;
    bit            counts;
    rda_pkg::res_t r;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= w.action;
    in_source_digits <= w.src;
    in_source_valid  <= w.srcv;
    in_target_digits <= w.tgt;
    in_target_valid  <= w.tgtv;
    do @(posedge clk); while (in_stall);
    counts = (w.action == rda_pkg::ACT_START) || run_flag;
    r = predict_roll(w);
    roll_q.push_back(typed ? want : r);
    if (counts) live_words++;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (roll_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_period(input logic [7:0] p);
    cfg_valid       <= 1'b1;
    cfg_step_period <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    period = p;
    n_cfg++;
  endtask

  // Result side: check every accepted word, then stall for a drawn count
  always @(posedge clk) begin : rx_side
    rda_pkg::res_t want;
    int            hold;
    if (rst_n && out_valid && !out_stall) begin
      if (roll_q.size() == 0) begin
        $error("result word with nothing expected");
        err_cnt++;
      end else begin
        want = roll_q.pop_front();
        n_checked++;
        if (out_done_res) n_done++;
        if (out_shown_digits !== want.shown_digits) begin
          $error("shown_digits: expected %h, got %h", want.shown_digits, out_shown_digits);
          err_cnt++;
        end
        if (out_segment_pattern !== want.segment_pattern) begin
          $error("segment_pattern: expected %h, got %h", want.segment_pattern,
                 out_segment_pattern);
          err_cnt++;
        end
        if (out_busy_res !== want.busy_res) begin
          $error("busy_res: expected %b, got %b", want.busy_res, out_busy_res);
          err_cnt++;
        end
        if (out_done_res !== want.done_res) begin
          $error("done_res: expected %b, got %b", want.done_res, out_done_res);
          err_cnt++;
        end
      end
      hold = rx_quiet ? 0 : $urandom_range(0, 4);
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  dir_row_t dir_tab[$];

  initial begin
    word_t w;
    int    p, n, cap, cut, eff, phase, n_anim;

    period    = rda_pkg::STEP_PERIOD_RST;
    part_mask = '0;
    run_flag  = 1'b0;
    tick_cnt  = '0;
    for (int i = 0; i < NDIG; i++) begin
      cur_d[i]  = '0;
      goal_d[i] = '0;
    end

    // period starts at its reset value
    dir_tab = '{
      '{NO_CFG, TICK_W, 1'b1, '{32'h0, 64'h0, 1'b0, 1'b0}},
      '{NO_CFG, '{rda_pkg::ACT_START, 32'hFFFFFFFF, 8'hFF, 32'h00000000, 8'hFF}, 1'b1,
        '{32'h99999999, 64'hDEDEDEDEDEDEDEDE, 1'b1, 1'b0}},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      // count already past the lowered period: step on this tick
      '{1, TICK_W, 1'b1, '{32'h0, 64'h7E7E7E7E7E7E7E7E, 1'b1, 1'b0}},
      '{NO_CFG, TICK_W, 1'b1, '{32'h0, 64'h7E7E7E7E7E7E7E7E, 1'b0, 1'b1}},
      '{NO_CFG, TICK_W, 1'b1, '{32'h0, 64'h7E7E7E7E7E7E7E7E, 1'b0, 1'b0}},
      '{NO_CFG, '{rda_pkg::ACT_START, 32'h00000000, 8'hFF, 32'h55555555, 8'hFF}, 1'b1,
        '{32'h0, 64'h7E7E7E7E7E7E7E7E, 1'b1, 1'b0}},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, '{rda_pkg::ACT_START, 32'h12345678, 8'h00, 32'h87654321, 8'h00}, 1'b1,
        '{32'h0, 64'h0, 1'b1, 1'b0}},
      '{NO_CFG, TICK_W, 1'b1, '{32'h0, 64'h0, 1'b0, 1'b1}},
      '{0, '{rda_pkg::ACT_START, 32'h0123ABCF, 8'hAA, 32'hFEDC9870, 8'h5A}, 1'b0,
        NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, '{rda_pkg::ACT_START, 32'h98765432, 8'hFF, 32'h23456789, 8'hFF}, 1'b0,
        NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES},
      '{NO_CFG, TICK_W, 1'b0, NO_RES}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].new_period != NO_CFG) begin
        drain_all();
        write_period(8'(dir_tab[k].new_period));
      end
      send_word(dir_tab[k].w, dir_tab[k].typed, dir_tab[k].want);
    end

    phase = 0;
    while (live_words < RUN_WORDS) begin
      drain_all();
      case (phase)
        1: p = 60;
        3: p = 255;
        5: p = 0;
        default: p = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      endcase
      write_period(8'(p));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      n_anim = (p > 12) ? 1 : $urandom_range(1, 4);
      repeat (n_anim) begin
        send_word(rand_word(rda_pkg::ACT_START), 1'b0, NO_RES);
        eff = (period == 0) ? 1 : int'(period);
        // long periods: cut the roll short, the next start restarts it
        cap = (eff <= 12) ? 6 * eff + 2 : 2 * eff + $urandom_range(0, 20);
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, cap) : 0;
        n = 0;
        while (run_flag && n < cap) begin
          if (n == cut) begin
            drain_all();
            write_period(8'($urandom_range(1, 12)));
          end
          w = rand_word(($urandom_range(0, 39) == 0) ? rda_pkg::ACT_START : rda_pkg::ACT_TICK);
          send_word(w, 1'b0, NO_RES);
          n++;
        end
        repeat ($urandom_range(0, 2)) send_word(rand_word(rda_pkg::ACT_TICK), 1'b0, NO_RES);
      end
      phase++;
    end

    drain_all();
    repeat (8) @(posedge clk);
    $display("checked %0d result words over %0d roll phases, %0d period writes",
             n_checked, phase, n_cfg);
    $display("%0d rolls finished with a done pulse", n_done);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rda_pkg.sv
hw/rtl/rda_lane.sv
hw/rtl/rda_outbuf.sv
hw/rtl/rolling_digit_animator_top.sv
test/tb_top.sv
